[src/nsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_pkg
// Shared types and constants of the non-overlapping substring matcher.
// ----------------------------------------------------------------------------
package nsm_pkg;

  // defaults for the top-level parameters
  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;

  // pattern storage: two 64-bit registers, sixteen bytes
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = 4;
  localparam int PAT_BITS  = PAT_BYTES * 8;

  // result field width
  localparam int OUT_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PLEN_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_req_t;

  typedef struct packed {
    logic             match_found;
    logic [OUT_W-1:0] match_start;
    logic [OUT_W-1:0] match_count;
    logic             text_done;
  } result_req_t;

  // per-cycle control handed to every cell of the window
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[src/nonoverlap_substring_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonoverlap_substring_matcher
// Streaming search for leftmost non-overlapping pattern matches.
// ----------------------------------------------------------------------------
// The block takes one text byte per request and returns one result per byte,
// one request per clock cycle while no held result is stalled. A row of
// MAX_PATTERN cells holds the most recent bytes, newest first; each accepted
// byte enters cell 0 and every cell hands its byte to the next. All cells
// compare their incoming byte against the matching pattern byte at once and
// the hits are and-ed, so a match is known in the cycle the byte arrives and
// the result is registered. A match counts only when enough bytes of the
// current text have arrived and the previous match has ended, so matches never
// overlap. Position and count saturate; end_of_text clears them and the window
// after its own result. The configuration port is always ready and should be
// written only while no text is in flight; pattern_length 0 acts as 1.
// ----------------------------------------------------------------------------
module nonoverlap_substring_matcher #(
  parameter int MAX_PATTERN   = nsm_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = nsm_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // text requests
  input  logic                              text_valid,
  output logic                              text_stall,
  input  nsm_pkg::text_req_t                text,
  // result requests
  output logic                              result_valid,
  input  logic                              result_stall,
  output nsm_pkg::result_req_t              result,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nsm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  // width for clamping the raw length register
  localparam int CW    = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
  // width for position arithmetic, room for here + 1
  localparam int PW    = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // configuration registers
  logic [PLEN_W-1:0]     pattern_length;
  logic [CFG_DATA_W-1:0] pattern_bytes_low;
  logic [CFG_DATA_W-1:0] pattern_bytes_high;

  // text state
  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] match_total;
  logic [LEN_W-1:0]         bytes_since_match;

  logic                     take;
  cell_ctrl_t               ctrl;
  logic [LEN_W-1:0]         len;
  logic [PAT_BITS-1:0]      pattern;
  logic [MAX_PATTERN-1:0]   hits;
  logic [7:0]               links [MAX_PATTERN];

  logic                     found;
  logic [LEN_W-1:0]         gap_inc;
  logic [PW-1:0]            here_plus;
  logic [PW-1:0]            start;
  logic [POSITION_BITS-1:0] total_inc;

  logic [POSITION_BITS-1:0] byte_position_next;
  logic [POSITION_BITS-1:0] match_total_next;
  logic [LEN_W-1:0]         bytes_since_match_next;
  result_req_t              result_next;

  // ------------------------------------------------------------------
  // configuration port, never stalls
  // ------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= PLEN_W'(1);
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[PLEN_W-1:0];
        REG_PATTERN_LOW:    pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_bytes_high <= cfg_data;
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // active length, clamped into 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (CW'(pattern_length) > CW'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(pattern_length);
    end
  end

  assign pattern = {pattern_bytes_high, pattern_bytes_low};

  // ------------------------------------------------------------------
  // handshake: output register parts the two sides
  // ------------------------------------------------------------------
  assign text_stall = result_valid && result_stall;
  assign take       = text_valid && !text_stall;
  assign ctrl.shift = take;
  assign ctrl.clear = text.end_of_text;

  // ------------------------------------------------------------------
  // window: row of cells, byte 0 newest
  // ------------------------------------------------------------------
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      nsm_cell #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX       (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .byte_in  (text.text_byte),
        .pattern  (pattern),
        .len      (len),
        .byte_out (links[k]),
        .hit      (hits[k])
      );
    end else begin : g_body
      nsm_cell #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX       (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .byte_in  (links[k-1]),
        .pattern  (pattern),
        .len      (len),
        .byte_out (links[k]),
        .hit      (hits[k])
      );
    end
  end

  // the oldest byte drops off the end of the row
  logic [7:0] oldest_unused;
  assign oldest_unused = links[MAX_PATTERN-1];

  // ------------------------------------------------------------------
  // match decision and counters
  // ------------------------------------------------------------------
  always_comb begin
    // gap since the last match, bumped before the check
    if (bytes_since_match < LEN_W'(MAX_PATTERN)) begin
      gap_inc = bytes_since_match + LEN_W'(1);
    end else begin
      gap_inc = bytes_since_match;
    end

    here_plus = PW'(byte_position) + PW'(1);
    start     = here_plus - PW'(len);
    total_inc = (match_total < POS_MAX) ? match_total + POSITION_BITS'(1) : match_total;

    // all cells agree, previous match over, enough text seen
    found = (&hits) && (gap_inc >= len) && (here_plus >= PW'(len)) &&
            (oldest_unused == oldest_unused);

    bytes_since_match_next = found ? '0 : gap_inc;
    match_total_next       = found ? total_inc : match_total;
    byte_position_next     = (byte_position < POS_MAX) ?
                             byte_position + POSITION_BITS'(1) : byte_position;

    result_next.match_found = found;
    result_next.match_start = found ? OUT_W'(start) : '0;
    result_next.match_count = OUT_W'(match_total_next);
    result_next.text_done   = text.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      match_total       <= '0;
      bytes_since_match <= LEN_W'(MAX_PATTERN);
    end else if (take) begin
      if (text.end_of_text) begin
        // new text starts clean after this result
        byte_position     <= '0;
        match_total       <= '0;
        bytes_since_match <= LEN_W'(MAX_PATTERN);
      end else begin
        byte_position     <= byte_position_next;
        match_total       <= match_total_next;
        bytes_since_match <= bytes_since_match_next;
      end
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

[src/nsm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_cell
// One window cell: holds one text byte, passes it on, compares its incoming byte.
// ----------------------------------------------------------------------------
module nsm_cell #(
  parameter int MAX_PATTERN = nsm_pkg::MAX_PATTERN_DEF,
  parameter int INDEX       = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nsm_pkg::cell_ctrl_t                 ctrl,
  input  logic [7:0]                          byte_in,
  input  logic [nsm_pkg::PAT_BITS-1:0]        pattern,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]    len,
  output logic [7:0]                          byte_out,
  output logic                                hit
);
  import nsm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IW    = (LEN_W > PAT_IDX_W + 1) ? LEN_W : PAT_IDX_W + 1;

  logic [7:0]    stored;
  logic          active;
  logic [IW-1:0] pat_idx;
  logic [7:0]    pat_byte;

  // cell k faces pattern byte len-1-k
  always_comb begin
    active  = LEN_W'(INDEX) < len;
    pat_idx = IW'(len) - IW'(INDEX) - IW'(1);
    if (pat_idx < IW'(PAT_BYTES)) begin
      pat_byte = pattern[pat_idx[PAT_IDX_W-1:0]*8 +: 8];
    end else begin
      pat_byte = 8'd0;
    end
    hit = !active || (byte_in == pat_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= 8'd0;
    end else if (ctrl.shift) begin
      stored <= ctrl.clear ? 8'd0 : byte_in;
    end
  end

  assign byte_out = stored;

endmodule
